[design/morse_keyed_audio_gate_macros.svh]
// Assertion macros used by the checker file of the Morse keyed audio gate.
// No dependencies; the including scope must provide clk and arst_n.
`ifndef MORSE_KEYED_AUDIO_GATE_MACROS_SVH
`define MORSE_KEYED_AUDIO_GATE_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define MKAG_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked property that must hold in reset as well
`define MKAG_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

[design/mkag_pkg.sv]
// Shared types and constants of the Morse keyed audio gate.
// No dependencies; imported by the top level, the symbol RAM user and the checker.
`timescale 1ns / 1ps
`default_nettype none

package mkag_pkg;

	// Field and register widths
	localparam int CMD_W   = 2;
	localparam int SYM_W   = 2;
	localparam int IDX_W   = 8;
	localparam int CNT_W   = 9;
	localparam int UNIT_W  = 20;
	localparam int TIME_W  = 22;
	localparam int LVL_W   = 16;
	localparam int GAIN_W  = 17;
	localparam int CFGI_W  = 2;
	localparam int CFGD_W  = 20;
	localparam int FRAC_W  = 15;

	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [SYM_W-1:0]  sym_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CFGI_W-1:0] cfg_idx_t;
	typedef logic [CFGD_W-1:0] cfg_data_t;
	typedef logic [GAIN_W-1:0] gain_t;
	typedef logic [TIME_W-1:0] time_t;

	// Item commands
	localparam cmd_t CMD_SAMPLE  = 2'd0;
	localparam cmd_t CMD_WRITE   = 2'd1;
	localparam cmd_t CMD_SILENCE = 2'd2;

	// Symbol codes
	localparam sym_t SYM_DOT   = 2'd0;
	localparam sym_t SYM_DASH  = 2'd1;
	localparam sym_t SYM_SPACE = 2'd2;

	// Register indexes
	localparam cfg_idx_t REG_FLOOR_GAIN   = 2'd0;
	localparam cfg_idx_t REG_UNIT_SAMPLES = 2'd1;
	localparam cfg_idx_t REG_ENV_STEP     = 2'd2;

	// Q1.15 unity and the round-toward-zero bias
	localparam gain_t UNITY          = 17'd32768;
	localparam int    ROUND_BIAS     = 32767;

	// Register reset values
	localparam logic [LVL_W-1:0]  FLOOR_RESET = 16'd0;
	localparam logic [UNIT_W-1:0] UNIT_RESET  = 20'd4800;
	localparam logic [LVL_W-1:0]  STEP_RESET  = 16'd32768;

endpackage

`default_nettype wire

[design/mkag_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; read during write at one address returns the old contents.
`timescale 1ns / 1ps
`default_nettype none

module mkag_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[design/morse_keyed_audio_gate.sv]
// Top level of the Morse keyed audio gate: pattern sequencer, envelope and gain multiply.
// Depends on mkag_pkg and mkag_ram.
`timescale 1ns / 1ps
`default_nettype none

// The gate takes one item per clock unless stalled, and hands out a gated sample for
// each accepted sample or silence item; write items give no result. The pattern lives
// in a MAX_SYMBOLS x 2 RAM whose read port always fetches the slot the sequencer will
// play next, so a symbol is ready by the time its element starts, and a write that hits
// that slot is forwarded. The element timer and envelope update in the accept cycle,
// one multiply stage follows, then the output register; a waiting result stalls the two
// stages only, so in_ready stays high whenever out_ready is high. Writing symbol_last
// sets the pattern length and restarts it; an empty pattern passes samples unchanged.
// Configuration writes take effect on the next cycle and are expected while idle.
module morse_keyed_audio_gate #(
	parameter int MAX_SYMBOLS = 256,
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// Configuration
	input  wire logic                       cfg_we,
	input  wire mkag_pkg::cfg_idx_t         cfg_index,
	input  wire mkag_pkg::cfg_data_t        cfg_data,
	// Input items
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire mkag_pkg::cmd_t             cmd,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
	input  wire mkag_pkg::idx_t             symbol_index,
	input  wire mkag_pkg::sym_t             symbol_code,
	input  wire logic                       symbol_last,
	// Result items
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_BITS-1:0]   out_sample
);

	import mkag_pkg::*;

	localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int PW = SAMPLE_BITS + GAIN_W + 1;

	// Configuration registers
	logic [LVL_W-1:0]  floor_q;
	logic [UNIT_W-1:0] unit_q;
	logic [LVL_W-1:0]  step_q;

	// Sequencer and envelope state
	logic [CNT_W-1:0] count_q, count_d;
	idx_t             play_q, play_d;
	time_t            elapsed_q, elapsed_d;
	time_t            elen_q, elen_d;
	logic             key_q, key_d;
	logic             gap_q, gap_d;
	gain_t            gain_q, gain_d;

	// Symbol RAM forwarding
	logic             fwd_hit_q, fwd_hit_d;
	sym_t             fwd_code_q;
	sym_t             ram_rdata;
	sym_t             cur_code;
	logic [AW-1:0]    ram_raddr;
	logic [AW-1:0]    ram_waddr;

	// Pipeline
	logic                          s1_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	gain_t                         gain_s1;
	logic                          out_valid_q;
	logic signed [PW-1:0]          prod_s2;
	logic signed [PW-1:0]          rnd;

	logic accept, s1_en, s2_en;
	logic is_sample, is_silence, wr_ok, restart, active, emits;
	time_t unit1, unit3;
	logic [CNT_W-1:0] play_inc;
	gain_t floor_eff, step_eff, env_sum, env_diff;

	// Handshake and stage enables
	assign s2_en    = !out_valid_q || out_ready;
	assign s1_en    = !s1_valid_q || s2_en;
	assign in_ready = s1_en;
	assign accept   = in_valid && in_ready;

	// Item decode
	always_comb begin
		is_sample  = 1'b0;
		is_silence = 1'b0;
		wr_ok      = 1'b0;
		case (cmd)
			CMD_SAMPLE:  is_sample  = accept;
			CMD_SILENCE: is_silence = accept;
			CMD_WRITE:   wr_ok      = accept && (32'(symbol_index) < MAX_SYMBOLS);
			default:     ;
		endcase
	end

	assign restart = is_silence || (wr_ok && symbol_last);
	assign active  = (count_q != '0);
	assign emits   = is_sample || is_silence;

	// Element lengths: zero unit acts as one
	assign unit1    = (unit_q == '0) ? time_t'(1) : time_t'(unit_q);
	assign unit3    = (unit1 << 1) + unit1;
	assign play_inc = CNT_W'(play_q) + CNT_W'(1);
	assign cur_code = fwd_hit_q ? fwd_code_q : ram_rdata;

	// Element sequencer
	always_comb begin
		count_d   = count_q;
		play_d    = play_q;
		elapsed_d = elapsed_q;
		elen_d    = elen_q;
		key_d     = key_q;
		gap_d     = gap_q;
		if (wr_ok && symbol_last) begin
			count_d = CNT_W'(symbol_index) + CNT_W'(1);
		end
		if (restart) begin
			play_d    = '0;
			elapsed_d = '0;
			elen_d    = '0;
			gap_d     = 1'b1;
		end else if (is_sample && active) begin
			if (elapsed_q >= elen_q) begin
				if (gap_q) begin
					play_d = (play_inc >= count_q) ? '0 : play_inc[IDX_W-1:0];
					case (cur_code)
						SYM_DOT: begin
							elen_d = unit1;
							key_d  = 1'b1;
						end
						SYM_DASH: begin
							elen_d = unit3;
							key_d  = 1'b1;
						end
						default: begin
							elen_d = unit1;
							key_d  = 1'b0;
						end
					endcase
					gap_d = 1'b0;
				end else begin
					elen_d = unit1;
					key_d  = 1'b0;
					gap_d  = 1'b1;
				end
				elapsed_d = time_t'(1);
			end else begin
				elapsed_d = elapsed_q + time_t'(1);
			end
		end
	end

	// Envelope ramp, saturating at unity and at the floor
	assign floor_eff = (GAIN_W'(floor_q) > UNITY) ? UNITY : GAIN_W'(floor_q);
	assign step_eff  = GAIN_W'(step_q);
	assign env_sum   = gain_q + step_eff;
	assign env_diff  = gain_q - floor_eff;

	always_comb begin
		gain_d = gain_q;
		if (is_sample && active) begin
			if (key_d) begin
				if (gain_q < UNITY) begin
					gain_d = (env_sum > UNITY) ? UNITY : env_sum;
				end
			end else if (gain_q > floor_eff) begin
				gain_d = (env_diff > step_eff) ? (gain_q - step_eff) : floor_eff;
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= FLOOR_RESET;
			unit_q  <= UNIT_RESET;
			step_q  <= STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FLOOR_GAIN:   floor_q <= cfg_data[LVL_W-1:0];
				REG_UNIT_SAMPLES: unit_q  <= cfg_data[UNIT_W-1:0];
				REG_ENV_STEP:     step_q  <= cfg_data[LVL_W-1:0];
				default:          ;
			endcase
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			play_q    <= '0;
			elapsed_q <= '0;
			elen_q    <= '0;
			key_q     <= 1'b0;
			gap_q     <= 1'b0;
			gain_q    <= '0;
			fwd_hit_q <= 1'b0;
		end else begin
			count_q   <= count_d;
			play_q    <= play_d;
			elapsed_q <= elapsed_d;
			elen_q    <= elen_d;
			key_q     <= key_d;
			gap_q     <= gap_d;
			gain_q    <= gain_d;
			fwd_hit_q <= fwd_hit_d;
		end
	end

	// Symbol RAM: prefetch the slot to be played next, forward a same-slot write
	assign ram_raddr = AW'(play_d);
	assign ram_waddr = AW'(symbol_index);
	assign fwd_hit_d = wr_ok && (ram_waddr == ram_raddr);

	always_ff @(posedge clk) begin
		fwd_code_q <= symbol_code;
	end

	mkag_ram #(
		.WIDTH(SYM_W),
		.DEPTH(MAX_SYMBOLS)
	) u_sym_ram (
		.clk  (clk),
		.we   (wr_ok),
		.waddr(ram_waddr),
		.wdata(symbol_code),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Stage 1: sample and gain; bypass uses unity, silence uses zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_en) begin
			s1_valid_q <= emits;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && emits) begin
			sample_s1 <= in_sample;
			if (is_silence) begin
				gain_s1 <= '0;
			end else if (active) begin
				gain_s1 <= gain_d;
			end else begin
				gain_s1 <= UNITY;
			end
		end
	end

	// Stage 2: product register feeding the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_en) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en && s1_valid_q) begin
			prod_s2 <= PW'(sample_s1) * $signed({1'b0, gain_s1});
		end
	end

	// Divide by unity with truncation toward zero
	assign rnd        = prod_s2 + (prod_s2[PW-1] ? PW'(ROUND_BIAS) : PW'(0));
	assign out_sample = rnd[SAMPLE_BITS+FRAC_W-1:FRAC_W];
	assign out_valid  = out_valid_q;

endmodule

`default_nettype wire

[design/mkag_checker.sv]
// Port-level checker of the Morse keyed audio gate and its bind to the top level.
// Depends on mkag_pkg and morse_keyed_audio_gate_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "morse_keyed_audio_gate_macros.svh"

module mkag_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire mkag_pkg::cmd_t                cmd,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic signed [SAMPLE_BITS-1:0] out_sample
);

	import mkag_pkg::*;

	// A stalled result holds
	`MKAG_ASSERT_CLK(a_out_hold, (out_valid && !out_ready |=> out_valid && $stable(out_sample)), "result changed while stalled")

	// An offered item is not withdrawn
	`MKAG_ASSERT_CLK(a_in_hold, (in_valid && !in_ready |=> in_valid), "input item withdrawn")

	// The gate never stalls its input while the output side is taking items
	`MKAG_ASSERT_ALWAYS(a_no_bubble, (out_ready |-> in_ready), "input stalled with output ready")

	// An accepted silence item comes out as zero when the output drains
	`MKAG_ASSERT_CLK(a_silence_zero, (in_valid && in_ready && cmd == CMD_SILENCE ##1 out_ready |=> out_valid && out_sample == '0), "silence item gave nonzero result")

endmodule

bind morse_keyed_audio_gate mkag_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mkag_checker (.*);

`default_nettype wire

[sim/tb_morse_keyed_audio_gate.sv]
// Self-checking testbench for the Morse keyed audio gate: random and directed items
// are checked against an in-bench model of the pattern timer and envelope.
// Depends on mkag_pkg and morse_keyed_audio_gate.
`timescale 1ns / 1ps

module tb_morse_keyed_audio_gate;
	import mkag_pkg::*;

	localparam int SAMPLE_W      = 24;
	localparam int MAX_SYM       = 256;
	localparam int FULL_GAIN     = int'(UNITY);
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;

	// Codes the package leaves unnamed: both are legal field values
	localparam cmd_t CMD_SPARE = 2'd3;
	localparam sym_t SYM_SPARE = 2'd3;

	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef struct packed {
		cmd_t                       cmd;
		logic signed [SAMPLE_W-1:0] smp;
		idx_t                       idx;
		sym_t                       code;
		logic                       last;
	} gate_item_t;

	logic                       clk;
	logic                       arst_n       = 1'b0;
	logic                       cfg_we       = 1'b0;
	cfg_idx_t                   cfg_index    = REG_FLOOR_GAIN;
	cfg_data_t                  cfg_data     = '0;
	logic                       in_valid     = 1'b0;
	logic                       in_ready;
	cmd_t                       cmd          = CMD_SAMPLE;
	logic signed [SAMPLE_W-1:0] in_sample    = '0;
	idx_t                       symbol_index = '0;
	sym_t                       symbol_code  = SYM_DOT;
	logic                       symbol_last  = 1'b0;
	logic                       out_valid;
	logic                       out_ready    = 1'b0;
	logic signed [SAMPLE_W-1:0] out_sample;

	morse_keyed_audio_gate #(
		.MAX_SYMBOLS(MAX_SYM),
		.SAMPLE_BITS(SAMPLE_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.in_sample   (in_sample),
		.symbol_index(symbol_index),
		.symbol_code (symbol_code),
		.symbol_last (symbol_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_sample  (out_sample)
	);

	// Items waiting to be offered, and gated samples waiting to come out
	gate_item_t                 pending_items[$];
	gate_item_t                 offered;
	logic signed [SAMPLE_W-1:0] gated_expect_q[$];
	logic signed [SAMPLE_W-1:0] want;

	// Model copy of the registers and the sequencer state
	int   floor_lvl = int'(FLOOR_RESET);
	int   unit_len  = int'(UNIT_RESET);
	int   step_lvl  = int'(STEP_RESET);
	sym_t pat_slot[MAX_SYM];
	int   pat_len   = 0;
	int   play_pos  = 0;
	int   elem_age  = 0;
	int   elem_len  = 0;
	int   env_level = 0;
	bit   key_down  = 1'b0;
	bit   after_gap = 1'b0;

	// Slots the stimulus has written so far; the sequencer never reads any other
	bit slot_loaded[MAX_SYM];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_req       = 1'b0;
	int hold_count     = 0;
	int fail_count     = 0;
	int items_taken    = 0;
	int results_seen   = 0;
	int settings_run   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Model: apply one accepted item, queue the gated sample it produces
	task automatic advance_gate(input gate_item_t it);
		int     unit;
		int     lo;
		sym_t   code;
		longint prod;
		unit = (unit_len == 0) ? 1 : unit_len;
		lo   = (floor_lvl > FULL_GAIN) ? FULL_GAIN : floor_lvl;
		case (it.cmd)
			CMD_SAMPLE: begin
				if (pat_len == 0) begin
					// empty pattern: bypass, nothing moves
					gated_expect_q.push_back(it.smp);
				end else begin
					// element over: a symbol follows a gap, a gap follows a symbol
					if (elem_age >= elem_len) begin
						if (after_gap) begin
							code = pat_slot[play_pos];
							play_pos++;
							if (play_pos >= pat_len)
								play_pos = 0;
							elem_len = (code == SYM_DASH) ? 3 * unit : unit;
							key_down = (code == SYM_DOT || code == SYM_DASH);
							after_gap = 1'b0;
						end else begin
							elem_len = unit;
							key_down = 1'b0;
							after_gap = 1'b1;
						end
						elem_age = 0;
					end
					elem_age++;
					// linear ramp, saturating at unity and at the floor
					if (key_down) begin
						if (env_level < FULL_GAIN) begin
							env_level = env_level + step_lvl;
							if (env_level > FULL_GAIN)
								env_level = FULL_GAIN;
						end
					end else if (env_level > lo) begin
						env_level = (env_level - lo > step_lvl) ? env_level - step_lvl : lo;
					end
					prod = longint'($signed(it.smp)) * env_level;
					gated_expect_q.push_back(SAMPLE_W'(prod / FULL_GAIN));
				end
			end
			CMD_WRITE: begin
				pat_slot[it.idx] = it.code;
				if (it.last) begin
					pat_len   = int'(it.idx) + 1;
					play_pos  = 0;
					elem_age  = 0;
					elem_len  = 0;
					after_gap = 1'b1;
				end
			end
			CMD_SILENCE: begin
				play_pos  = 0;
				elem_age  = 0;
				elem_len  = 0;
				after_gap = 1'b1;
				gated_expect_q.push_back('0);
			end
			default: begin
			end
		endcase
	endtask

	// Sender: predict on accept, then offer the next item unless idling
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				advance_gate(offered);
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					offered = pending_items.pop_front();
					in_valid     <= 1'b1;
					cmd          <= offered.cmd;
					in_sample    <= offered.smp;
					symbol_index <= offered.idx;
					symbol_code  <= offered.code;
					symbol_last  <= offered.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && hold_count < HOLD_CYCLES) begin
			out_ready  <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (gated_expect_q.size() == 0) begin
				$error("out_sample: expected no result, actual %0d", out_sample);
				fail_count++;
			end else begin
				want = gated_expect_q.pop_front();
				if (out_sample !== want) begin
					$error("out_sample: expected %0d, actual %0d", want, out_sample);
					fail_count++;
				end
			end
		end
	end

	task automatic queue_item(input cmd_t c, input logic signed [SAMPLE_W-1:0] s,
			input idx_t i, input sym_t k, input logic l);
		gate_item_t it;
		it.cmd  = c;
		it.smp  = s;
		it.idx  = i;
		it.code = k;
		it.last = l;
		if (c == CMD_WRITE)
			slot_loaded[i] = 1'b1;
		pending_items.push_back(it);
	endtask

	// Item with random filler in the fields its command ignores
	task automatic queue_filler(input cmd_t c);
		queue_item(c, SAMPLE_W'($urandom), idx_t'($urandom), sym_t'($urandom),
			1'($urandom));
	endtask

	function automatic sym_t pick_code();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return SYM_DOT;
			4, 5, 6, 7: return SYM_DASH;
			8: return SYM_SPACE;
			default: return SYM_SPARE;
		endcase
	endfunction

	// Full pattern: slots 0..len-1, the last one closing it
	task automatic load_pattern(input int len);
		for (int i = 0; i < len; i++)
			queue_item(CMD_WRITE, SAMPLE_W'($urandom), idx_t'(i), pick_code(), i == len - 1);
	endtask

	task automatic run_traffic(input int n);
		int                         done;
		int                         pick;
		int                         len;
		int                         top;
		logic signed [SAMPLE_W-1:0] s;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 66) begin
				case ($urandom_range(0, 9))
					0: s = SMP_MAX;
					1: s = SMP_MIN;
					2: s = SAMPLE_W'(int'($urandom_range(0, 255)) - 128);
					default: s = SAMPLE_W'($urandom);
				endcase
				queue_item(CMD_SAMPLE, s, idx_t'($urandom), sym_t'($urandom), 1'($urandom));
				done++;
			end else if (pick < 74) begin
				queue_filler(CMD_SILENCE);
				done++;
			end else if (pick < 84) begin
				len = $urandom_range(1, 6);
				load_pattern(len);
				done += len;
			end else if (pick < 91) begin
				// stray write, pattern length untouched
				queue_item(CMD_WRITE, SAMPLE_W'($urandom), idx_t'($urandom), pick_code(),
					1'b0);
				done++;
			end else if (pick < 96) begin
				// closing write on some loaded slot: new length, restart mid-pattern
				top = 0;
				while (top < MAX_SYM && slot_loaded[top])
					top++;
				if (top > 0) begin
					queue_item(CMD_WRITE, SAMPLE_W'($urandom),
						idx_t'($urandom_range(0, top - 1)), pick_code(), 1'b1);
					done++;
				end
			end else begin
				// unused command, dropped by the block
				queue_filler(CMD_SPARE);
			end
		end
	endtask

	task automatic write_reg(input cfg_idx_t r, input int v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= cfg_data_t'(v);
		case (r)
			REG_FLOOR_GAIN:   floor_lvl = v & 'hFFFF;
			REG_UNIT_SAMPLES: unit_len  = v & 'hFFFFF;
			REG_ENV_STEP:     step_lvl  = v & 'hFFFF;
			default: begin
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until everything offered is accepted and every result is back
	task automatic wait_drain();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || gated_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input int fl, input int un, input int st, input int sp,
			input int rp, input int n, input bit pressure);
		write_reg(REG_FLOOR_GAIN, fl);
		write_reg(REG_UNIT_SAMPLES, un);
		write_reg(REG_ENV_STEP, st);
		send_idle_pct  = sp;
		recv_stall_pct = rp;
		if (pressure)
			load_pattern(MAX_SYM);
		run_traffic(n);
		if (pressure) begin
			// output held off while items keep coming: the block must back up
			hold_req = 1'b1;
			do
				@(negedge clk);
			while (hold_count < HOLD_CYCLES);
			hold_req = 1'b0;
		end
		wait_drain();
		settings_run++;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Empty pattern: extremes pass straight through, silence, unused command, stray write
		queue_item(CMD_SAMPLE, SMP_MAX, idx_t'($urandom), sym_t'($urandom), 1'($urandom));
		queue_item(CMD_SAMPLE, SMP_MIN, idx_t'($urandom), sym_t'($urandom), 1'($urandom));
		queue_item(CMD_SAMPLE, SAMPLE_W'(-1), idx_t'($urandom), sym_t'($urandom),
			1'($urandom));
		queue_filler(CMD_SPARE);
		queue_filler(CMD_SILENCE);
		queue_item(CMD_WRITE, SAMPLE_W'($urandom), 8'hFF, SYM_DASH, 1'b0);
		wait_drain();

		// Short units and a two-sample ramp; every symbol code incl. the unused one
		write_reg(REG_UNIT_SAMPLES, 1);
		write_reg(REG_ENV_STEP, 16384);
		write_reg(REG_FLOOR_GAIN, 4096);
		queue_item(CMD_WRITE, SAMPLE_W'($urandom), 8'd0, SYM_DOT, 1'b0);
		queue_item(CMD_WRITE, SAMPLE_W'($urandom), 8'd1, SYM_DASH, 1'b0);
		queue_item(CMD_WRITE, SAMPLE_W'($urandom), 8'd2, SYM_SPACE, 1'b0);
		queue_item(CMD_WRITE, SAMPLE_W'($urandom), 8'd3, SYM_SPARE, 1'b1);
		for (int i = 0; i < 12; i++)
			queue_item(CMD_SAMPLE, (i % 2) ? SMP_MIN : SMP_MAX, idx_t'($urandom),
				sym_t'($urandom), 1'($urandom));
		wait_drain();
		settings_run++;

		// floor, unit, step, sender idle %, receiver stall %, items, pressure
		run_phase(0, 1, 32768, 0, 0, 150, 1'b0);
		run_phase(8192, 3, 4096, 73, 0, 150, 1'b0);
		run_phase(32768, 2, 1, 0, 73, 150, 1'b0);
		run_phase(65535, 0, 0, 21, 21, 150, 1'b0);
		run_phase(1, 1048575, 65535, 0, 0, 60, 1'b0);
		run_phase(12000, 5, 1000, 0, 0, 150, 1'b1);
		run_phase(300, 2, 300, 21, 21, 150, 1'b0);

		$display("Run covered %0d items and %0d gated results over %0d register settings,",
			items_taken, results_seen, settings_run);
		$display("including bypass, restarts, ramp saturation and a long output hold-off.");
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Timeout with %0d results outstanding", gated_expect_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
+incdir+design
design/mkag_pkg.sv
design/mkag_ram.sv
design/morse_keyed_audio_gate.sv
design/mkag_checker.sv
sim/tb_morse_keyed_audio_gate.sv
